// ===== hw/rtl/slbs_pkg.sv =====
// shared types, constants and pattern tables for the status led blink sequencer
package slbs_pkg;

  localparam int unsigned ListDepthDef = 6;

  localparam int unsigned CodeW    = 4;
  localparam int unsigned ReqW     = 3;
  localparam int unsigned StaW     = 4;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned PollW    = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned BlinkW   = 3;
  localparam int unsigned KindW    = 3;
  localparam int unsigned ColourW  = 2;
  localparam int unsigned CountW   = 3;

  localparam logic [CodeW-1:0] CodeInit     = 4'd0;
  localparam logic [CodeW-1:0] CodeReady    = 4'd1;
  localparam logic [CodeW-1:0] CodeNoDevice = 4'd9;

  localparam logic [ReqW-1:0] ReqAdd    = 3'd0;
  localparam logic [ReqW-1:0] ReqRemove = 3'd1;
  localparam logic [ReqW-1:0] ReqTick   = 3'd2;
  localparam logic [ReqW-1:0] ReqPoll   = 3'd3;
  localparam logic [ReqW-1:0] ReqQuery  = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgSlow   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFast   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPause  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgUnk    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDeb    = 3'd4;

  localparam logic [KindW-1:0] KindNone    = 3'd0;
  localparam logic [KindW-1:0] KindSteady  = 3'd1;
  localparam logic [KindW-1:0] KindSlow    = 3'd2;
  localparam logic [KindW-1:0] KindFast    = 3'd3;
  localparam logic [KindW-1:0] KindUnknown = 3'd4;

  localparam logic [ColourW-1:0] ColNone   = 2'd0;
  localparam logic [ColourW-1:0] ColRed    = 2'd1;
  localparam logic [ColourW-1:0] ColYellow = 2'd2;
  localparam logic [ColourW-1:0] ColGreen  = 2'd3;

  typedef enum logic [3:0] {
    OpNone,
    OpLatch,
    OpDrop,
    OpAppend,
    OpRemove,
    OpSnap,
    OpStart,
    OpCount,
    OpAdvance,
    OpPoll,
    OpResult
  } op_e;

  typedef struct packed {
    op_e  op;
    logic nodev;
  } cmd_t;

  typedef struct packed {
    logic [ReqW-1:0] req;
    logic            phase_idle;
    logic            list_empty;
    logic            timer_last;
    logic            round_more;
    logic            poll_hit;
    logic            poll_empty;
  } stat_t;

  function automatic logic [TimeW-1:0] dur(input logic [TimeW-1:0] v);
    return (v == '0) ? TimeW'(1) : v;
  endfunction

  function automatic logic [KindW-1:0] pat_kind(input logic [CodeW-1:0] code);
    logic [KindW-1:0] k;
    case (code)
      4'd0, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd11: k = KindSlow;
      4'd5, 4'd13:                               k = KindFast;
      4'd2, 4'd9, 4'd12:                         k = KindSteady;
      4'd14, 4'd15:                              k = KindUnknown;
      default:                                   k = KindNone;
    endcase
    return k;
  endfunction

  function automatic logic [ColourW-1:0] pat_colour(input logic [CodeW-1:0] code);
    logic [ColourW-1:0] c;
    case (code)
      4'd2, 4'd3, 4'd6, 4'd7, 4'd8: c = ColRed;
      4'd4, 4'd9, 4'd11:            c = ColYellow;
      4'd0, 4'd5, 4'd12, 4'd13:     c = ColGreen;
      default:                      c = ColNone;
    endcase
    return c;
  endfunction

  function automatic logic [BlinkW-1:0] pat_count(input logic [CodeW-1:0] code);
    logic [BlinkW-1:0] n;
    case (code)
      4'd0:                     n = 3'd1;
      4'd3, 4'd4, 4'd5:         n = 3'd2;
      4'd6, 4'd11, 4'd13:       n = 3'd3;
      4'd7, 4'd8:               n = 3'd4;
      default:                  n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/slbs_req_if.sv =====
// request channel: valid, ready and the request fields
interface slbs_req_if;
  import slbs_pkg::*;

  logic                valid;
  logic                ready;
  logic [ReqW-1:0]     req_type;
  logic [CodeW-1:0]    status_code;
  logic [StaW-1:0]     station_count;

  modport source (output valid, output req_type, output status_code,
                  output station_count, input ready);
  modport sink (input valid, input req_type, input status_code,
                input station_count, output ready);
endinterface

// ===== hw/rtl/slbs_res_if.sv =====
// result channel: valid, ready and the led and status fields
interface slbs_res_if;
  import slbs_pkg::*;

  logic              valid;
  logic              ready;
  logic              red_led;
  logic              ylw_led;
  logic              grn_led;
  logic              code_active;
  logic [CountW-1:0] active_count;

  modport source (output valid, output red_led, output ylw_led, output grn_led,
                  output code_active, output active_count, input ready);
  modport sink (input valid, input red_led, input ylw_led, input grn_led,
                input code_active, input active_count, output ready);
endinterface

// ===== hw/rtl/slbs_ctrl.sv =====
// controller state machine sequencing the datapath steps of one transaction
module slbs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output slbs_pkg::cmd_t  cmd_o,
  input  slbs_pkg::stat_t stat_i
);
  import slbs_pkg::*;

  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SDecode  = 4'd1;
  localparam logic [3:0] SDrop    = 4'd2;
  localparam logic [3:0] SAppend  = 4'd3;
  localparam logic [3:0] SRemove  = 4'd4;
  localparam logic [3:0] SSnap    = 4'd5;
  localparam logic [3:0] SStart   = 4'd6;
  localparam logic [3:0] SCount   = 4'd7;
  localparam logic [3:0] SAdvance = 4'd8;
  localparam logic [3:0] SRestart = 4'd9;
  localparam logic [3:0] SPoll    = 4'd10;
  localparam logic [3:0] SCheck   = 4'd11;
  localparam logic [3:0] SResult  = 4'd12;

  logic [3:0] state_q, state_d;
  logic       nodev_q, nodev_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    nodev_d     = nodev_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    cmd_o.op    = OpNone;
    cmd_o.nodev = nodev_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OpLatch;
          nodev_d  = 1'b0;
          state_d  = SDecode;
        end
      end
      SDecode: begin
        unique case (stat_i.req)
          ReqAdd:    state_d = SDrop;
          ReqRemove: state_d = SRemove;
          ReqTick:   state_d = stat_i.phase_idle ? SSnap : SCount;
          ReqPoll:   state_d = SPoll;
          default:   state_d = SResult;
        endcase
      end
      SDrop: begin
        cmd_o.op = OpDrop;
        state_d  = SAppend;
      end
      SAppend: begin
        cmd_o.op = OpAppend;
        state_d  = SResult;
      end
      SRemove: begin
        cmd_o.op = OpRemove;
        state_d  = SResult;
      end
      SSnap: begin
        cmd_o.op = OpSnap;
        state_d  = stat_i.list_empty ? SResult : SStart;
      end
      SStart: begin
        cmd_o.op = OpStart;
        state_d  = SCount;
      end
      SCount: begin
        cmd_o.op = OpCount;
        state_d  = stat_i.timer_last ? SAdvance : SResult;
      end
      SAdvance: begin
        cmd_o.op = OpAdvance;
        state_d  = stat_i.round_more ? SRestart : SResult;
      end
      SRestart: begin
        cmd_o.op = OpStart;
        state_d  = SResult;
      end
      SPoll: begin
        cmd_o.op = OpPoll;
        state_d  = SCheck;
      end
      SCheck: begin
        if (stat_i.poll_hit) begin
          nodev_d = 1'b1;
          state_d = stat_i.poll_empty ? SDrop : SRemove;
        end else begin
          state_d = SResult;
        end
      end
      SResult: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OpResult;
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      nodev_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nodev_q     <= nodev_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/slbs_dpath.sv =====
// datapath: status list, round snapshot, pattern timing, poll debounce, result register
module slbs_dpath #(
  parameter int unsigned ListDepth = slbs_pkg::ListDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  slbs_pkg::cmd_t                 cmd_i,
  output slbs_pkg::stat_t                stat_o,
  input  logic [slbs_pkg::ReqW-1:0]      req_type_i,
  input  logic [slbs_pkg::CodeW-1:0]     status_code_i,
  input  logic [slbs_pkg::StaW-1:0]      station_count_i,
  input  logic                           cfg_we_i,
  input  logic [slbs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [slbs_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                           red_led_o,
  output logic                           ylw_led_o,
  output logic                           grn_led_o,
  output logic                           code_active_o,
  output logic [slbs_pkg::CountW-1:0]    active_count_o
);
  import slbs_pkg::*;

  localparam int unsigned CntW = $clog2(ListDepth + 1);
  localparam int unsigned IdxW = (ListDepth > 1) ? $clog2(ListDepth) : 1;

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhOn    = 3'd1;
  localparam logic [2:0] PhOff   = 3'd2;
  localparam logic [2:0] PhWait  = 3'd3;
  localparam logic [2:0] PhPause = 3'd4;

  // latched transaction
  logic [ReqW-1:0]  req_q;
  logic [CodeW-1:0] code_q;
  logic [StaW-1:0]  sta_q;

  // timing registers
  logic [TimeW-1:0] slow_q, fast_q, pause_q, unk_q;
  logic [PollW-1:0] deb_q;

  logic [CodeW-1:0] list_q [ListDepth];
  logic [CodeW-1:0] list_d [ListDepth];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CodeW-1:0] copy_q [ListDepth];
  logic [CodeW-1:0] copy_d [ListDepth];
  logic [CntW-1:0]  rcnt_q, rcnt_d;
  logic [CntW-1:0]  ridx_q, ridx_d;
  logic [2:0]       phase_q, phase_d;
  logic [BlinkW-1:0] blinks_q, blinks_d;
  logic [TimeW-1:0] timer_q, timer_d;
  logic [PollW-1:0] erun_q, erun_d, prun_q, prun_d;

  logic             red_q, ylw_q, grn_q, active_q;
  logic [CountW-1:0] count_q;

  logic [CodeW-1:0] op_code, tgt_code, cur_code;
  logic [ListDepth-1:0] match_tgt, match_req, match_nd;
  logic [IdxW-1:0]  tgt_pos;
  logic             tgt_found;
  logic [KindW-1:0] cur_kind;
  logic [TimeW-1:0] half;
  logic [2:0]       start_phase;
  logic [BlinkW-1:0] start_blinks;
  logic [TimeW-1:0] start_timer;
  logic [CntW-1:0]  next_idx;
  logic             more;
  logic [BlinkW-1:0] blinks_dec;
  logic [ColourW-1:0] lit;

  always_comb begin
    op_code  = cmd_i.nodev ? CodeNoDevice : code_q;
    tgt_code = (cmd_i.op == OpDrop) ? CodeReady : op_code;
  end

  // compare every live entry against the codes of interest
  always_comb begin
    tgt_pos = '0;
    for (int i = 0; i < ListDepth; i++) begin
      match_tgt[i] = (CntW'(i) < cnt_q) && (list_q[i] == tgt_code);
      match_req[i] = (CntW'(i) < cnt_q) && (list_q[i] == code_q);
      match_nd[i]  = (CntW'(i) < cnt_q) && (list_q[i] == CodeNoDevice);
    end
    for (int i = ListDepth - 1; i >= 0; i--) begin
      if (match_tgt[i]) begin
        tgt_pos = IdxW'(i);
      end
    end
    tgt_found = |match_tgt;
  end

  always_comb begin
    cur_code = (ridx_q < CntW'(ListDepth)) ? copy_q[ridx_q[IdxW-1:0]] : CodeInit;
    cur_kind = pat_kind(cur_code);
    half     = dur((cur_kind == KindFast) ? fast_q : slow_q);

    start_phase  = PhPause;
    start_blinks = blinks_q;
    start_timer  = dur(pause_q);
    if (cur_kind == KindSlow || cur_kind == KindFast) begin
      start_phase  = PhOn;
      start_blinks = pat_count(cur_code);
      start_timer  = half;
    end else if (cur_kind == KindUnknown) begin
      start_phase = PhWait;
      start_timer = dur(unk_q);
    end

    next_idx   = ridx_q + CntW'(1);
    more       = (next_idx < rcnt_q) && (next_idx < CntW'(ListDepth));
    blinks_dec = (blinks_q != '0) ? blinks_q - BlinkW'(1) : '0;

    lit = ColNone;
    if (phase_q == PhOn || (phase_q == PhPause && cur_kind == KindSteady)) begin
      lit = pat_colour(cur_code);
    end
  end

  always_comb begin
    stat_o.req        = req_q;
    stat_o.phase_idle = (phase_q == PhIdle);
    stat_o.list_empty = (cnt_q == '0);
    stat_o.timer_last = (timer_q <= TimeW'(1));
    stat_o.round_more = (phase_q == PhPause) && more;
    stat_o.poll_empty = (sta_q == '0);
    stat_o.poll_hit   = (sta_q == '0) ? (erun_q >= deb_q) : (prun_q >= deb_q);
  end

  always_comb begin
    list_d   = list_q;
    cnt_d    = cnt_q;
    copy_d   = copy_q;
    rcnt_d   = rcnt_q;
    ridx_d   = ridx_q;
    phase_d  = phase_q;
    blinks_d = blinks_q;
    timer_d  = timer_q;
    erun_d   = erun_q;
    prun_d   = prun_q;

    unique case (cmd_i.op)
      OpDrop, OpRemove: begin
        if (tgt_found && (cmd_i.op == OpRemove || op_code != CodeReady)) begin
          for (int j = 0; j < ListDepth - 1; j++) begin
            if (IdxW'(j) >= tgt_pos && CntW'(j + 1) < cnt_q) begin
              list_d[j] = list_q[j + 1];
            end
          end
          cnt_d = cnt_q - CntW'(1);
        end
      end
      OpAppend: begin
        if (!tgt_found && cnt_q < CntW'(ListDepth)) begin
          list_d[cnt_q[IdxW-1:0]] = op_code;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      OpSnap: begin
        ridx_d = '0;
        if (|match_nd) begin
          copy_d[0] = CodeNoDevice;
          rcnt_d    = CntW'(1);
        end else begin
          copy_d = list_q;
          rcnt_d = cnt_q;
        end
      end
      OpStart: begin
        phase_d  = start_phase;
        blinks_d = start_blinks;
        timer_d  = start_timer;
      end
      OpCount: begin
        if (timer_q != '0) begin
          timer_d = timer_q - TimeW'(1);
        end
      end
      OpAdvance: begin
        unique case (phase_q)
          PhOn: begin
            phase_d = PhOff;
            timer_d = half;
          end
          PhOff: begin
            blinks_d = blinks_dec;
            if (blinks_dec != '0) begin
              phase_d = PhOn;
              timer_d = half;
            end else begin
              phase_d = PhPause;
              timer_d = dur(pause_q);
            end
          end
          PhWait: begin
            phase_d = PhPause;
            timer_d = dur(pause_q);
          end
          PhPause: begin
            ridx_d = next_idx;
            if (!more) begin
              phase_d = PhIdle;
              timer_d = '0;
            end
          end
          default: begin
            phase_d = PhIdle;
            timer_d = '0;
          end
        endcase
      end
      OpPoll: begin
        if (sta_q == '0) begin
          if (erun_q != '1) begin
            erun_d = erun_q + PollW'(1);
          end
          prun_d = '0;
        end else begin
          if (prun_q != '1) begin
            prun_d = prun_q + PollW'(1);
          end
          erun_d = '0;
        end
      end
      OpNone, OpLatch, OpResult: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_q   <= TimeW'(500);
      fast_q   <= TimeW'(100);
      pause_q  <= TimeW'(1500);
      unk_q    <= TimeW'(2000);
      deb_q    <= PollW'(2);
      for (int i = 0; i < ListDepth; i++) begin
        list_q[i] <= CodeInit;
      end
      cnt_q    <= CntW'(1);
      rcnt_q   <= '0;
      ridx_q   <= '0;
      phase_q  <= PhIdle;
      blinks_q <= '0;
      timer_q  <= '0;
      erun_q   <= '0;
      prun_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgSlow:  slow_q  <= cfg_data_i;
          CfgFast:  fast_q  <= cfg_data_i;
          CfgPause: pause_q <= cfg_data_i;
          CfgUnk:   unk_q   <= cfg_data_i;
          CfgDeb:   deb_q   <= cfg_data_i[PollW-1:0];
          default: begin
          end
        endcase
      end
      list_q   <= list_d;
      cnt_q    <= cnt_d;
      rcnt_q   <= rcnt_d;
      ridx_q   <= ridx_d;
      phase_q  <= phase_d;
      blinks_q <= blinks_d;
      timer_q  <= timer_d;
      erun_q   <= erun_d;
      prun_q   <= prun_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    copy_q <= copy_d;
    if (cmd_i.op == OpLatch) begin
      req_q  <= req_type_i;
      code_q <= status_code_i;
      sta_q  <= station_count_i;
    end
    if (cmd_i.op == OpResult) begin
      red_q    <= (lit == ColRed);
      ylw_q    <= (lit == ColYellow);
      grn_q    <= (lit == ColGreen);
      active_q <= |match_req;
      count_q  <= CountW'(cnt_q);
    end
  end

  assign red_led_o      = red_q;
  assign ylw_led_o      = ylw_q;
  assign grn_led_o      = grn_q;
  assign code_active_o  = active_q;
  assign active_count_o = count_q;

endmodule

// ===== hw/rtl/status_led_blink_sequencer_core.sv =====
// top level of the status led blink sequencer
// an accepted transaction reaches its result as the controller walks list edits, the
// round snapshot and the pattern timer step by step
// one transaction at a time: the next is accepted on the cycle after
// the result is registered, even while that result still waits to be taken
// reset: list holds the initialising code only, timings at their defaults
module status_led_blink_sequencer_core #(
  parameter int unsigned ListDepth = slbs_pkg::ListDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  slbs_req_if.sink                      req_i,
  slbs_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  logic [slbs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [slbs_pkg::CfgDataW-1:0] cfg_data_i
);
  import slbs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  slbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  slbs_dpath #(
    .ListDepth (ListDepth)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .req_type_i      (req_i.req_type),
    .status_code_i   (req_i.status_code),
    .station_count_i (req_i.station_count),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .red_led_o       (res_o.red_led),
    .ylw_led_o       (res_o.ylw_led),
    .grn_led_o       (res_o.grn_led),
    .code_active_o   (res_o.code_active),
    .active_count_o  (res_o.active_count)
  );

endmodule

// ===== sim/tb_status_led_blink_sequencer_core.sv =====
// testbench for the status led blink sequencer core: a stimulus table, then random transactions
`timescale 1ns / 1ps

module tb_status_led_blink_sequencer_core;
  import slbs_pkg::*;

  typedef enum logic [2:0] {PhIdle, PhOn, PhOff, PhWait, PhPause} blink_phase_e;

  typedef struct packed {
    logic              red;
    logic              yellow;
    logic              green;
    logic              active;
    logic [CountW-1:0] count;
  } led_res_t;

  typedef struct packed {
    logic [ReqW-1:0]  req;
    logic [CodeW-1:0] code;
    logic [StaW-1:0]  sta;
    logic             typed;
    led_res_t         want;
  } dir_row_t;

  localparam int unsigned ListD       = ListDepthDef;
  localparam int unsigned DirRows     = 24;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 300000;
  localparam int          RunMax      = 255;

  localparam logic [ReqW-1:0]    ReqSpareLo  = 3'd5;
  localparam logic [ReqW-1:0]    ReqSpareMid = 3'd6;
  localparam logic [ReqW-1:0]    ReqSpareHi  = 3'd7;
  localparam logic [CfgIdxW-1:0] CfgSpareLo  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSpareHi  = 3'd7;

  localparam logic [TimeW-1:0] RstSlow  = 16'd500;
  localparam logic [TimeW-1:0] RstFast  = 16'd100;
  localparam logic [TimeW-1:0] RstPause = 16'd1500;
  localparam logic [TimeW-1:0] RstUnk   = 16'd2000;
  localparam logic [PollW-1:0] RstDeb   = 8'd2;

  // pattern tables, code 15 first
  localparam logic [15:0][KindW-1:0] KindTab = {
    KindUnknown, KindUnknown, KindFast, KindSteady, KindSlow, KindNone, KindSteady, KindSlow,
    KindSlow, KindSlow, KindFast, KindSlow, KindSlow, KindSteady, KindNone, KindSlow};
  localparam logic [15:0][ColourW-1:0] ColourTab = {
    ColNone, ColNone, ColGreen, ColGreen, ColYellow, ColNone, ColYellow, ColRed,
    ColRed, ColRed, ColGreen, ColYellow, ColRed, ColRed, ColNone, ColGreen};
  localparam logic [15:0][BlinkW-1:0] BlinkTab = {
    3'd0, 3'd0, 3'd3, 3'd0, 3'd3, 3'd0, 3'd0, 3'd4,
    3'd4, 3'd3, 3'd2, 3'd2, 3'd2, 3'd0, 3'd0, 3'd1};

  logic               clk = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  slbs_req_if req_ch ();
  slbs_res_if res_ch ();

  status_led_blink_sequencer_core i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .req_i      (req_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // sequencer state as predicted
  logic [TimeW-1:0] slow_hp, fast_hp, pause_len, unk_wait;
  logic [PollW-1:0] deb_polls;
  logic [CodeW-1:0] codes [ListD];
  logic [CodeW-1:0] snap [ListD];
  int               n_codes, snap_n, snap_idx, blinks, empty_run, present_run;
  blink_phase_e     ph;
  logic [TimeW-1:0] tmr;

  led_res_t   pending_leds [$];
  led_res_t   due;
  dir_row_t   dir_tab [DirRows];
  int         mismatch_cnt = 0;
  int         cycle_cnt = 0;
  int         hold_left = 0;
  int         stall_left = 0;
  bit         idle_on = 1'b1;

  function automatic logic [TimeW-1:0] at_least_one(input logic [TimeW-1:0] v);
    return (v == '0) ? TimeW'(1) : v;
  endfunction

  function automatic int find_code(input logic [CodeW-1:0] c);
    for (int i = 0; i < n_codes; i++) begin
      if (codes[i] == c) return i;
    end
    return -1;
  endfunction

  function automatic void drop_code(input logic [CodeW-1:0] c);
    int p;
    p = find_code(c);
    if (p < 0) return;
    for (int j = p; j + 1 < n_codes; j++) codes[j] = codes[j + 1];
    n_codes--;
  endfunction

  function automatic void add_code(input logic [CodeW-1:0] c);
    if (c != CodeReady) drop_code(CodeReady);
    if (find_code(c) < 0 && n_codes < ListD) begin
      codes[n_codes] = c;
      n_codes++;
    end
  endfunction

  function automatic logic [CodeW-1:0] cur_code();
    return (snap_idx < ListD) ? snap[snap_idx] : '0;
  endfunction

  function automatic logic [TimeW-1:0] half_for(input logic [CodeW-1:0] c);
    return at_least_one(KindTab[c] == KindFast ? fast_hp : slow_hp);
  endfunction

  function automatic void load_pattern(input logic [CodeW-1:0] c);
    case (KindTab[c])
      KindSlow, KindFast: begin
        ph     = PhOn;
        blinks = BlinkTab[c];
        tmr    = half_for(c);
      end
      KindUnknown: begin
        ph  = PhWait;
        tmr = at_least_one(unk_wait);
      end
      default: begin
        ph  = PhPause;
        tmr = at_least_one(pause_len);
      end
    endcase
  endfunction

  function automatic led_res_t blink_step(input logic [ReqW-1:0] req,
                                          input logic [CodeW-1:0] code,
                                          input logic [StaW-1:0] sta);
    led_res_t         r;
    logic [ColourW-1:0] lit;
    logic [CodeW-1:0] cc;
    bit               run;
    run = 1'b1;
    case (req)
      ReqAdd:    add_code(code);
      ReqRemove: drop_code(code);
      ReqTick: begin
        if (ph == PhIdle) begin
          snap_idx = 0;
          if (find_code(CodeNoDevice) >= 0) begin
            snap[0] = CodeNoDevice;
            snap_n  = 1;
          end else begin
            for (int i = 0; i < n_codes; i++) snap[i] = codes[i];
            snap_n = n_codes;
          end
          run = (snap_n != 0);
          if (run) load_pattern(cur_code());
        end
        if (run) begin
          if (tmr != '0) tmr--;
          if (tmr == '0) begin
            case (ph)
              PhOn: begin
                ph  = PhOff;
                tmr = half_for(cur_code());
              end
              PhOff: begin
                if (blinks != 0) blinks--;
                if (blinks != 0) begin
                  ph  = PhOn;
                  tmr = half_for(cur_code());
                end else begin
                  ph  = PhPause;
                  tmr = at_least_one(pause_len);
                end
              end
              PhWait: begin
                ph  = PhPause;
                tmr = at_least_one(pause_len);
              end
              PhPause: begin
                snap_idx++;
                if (snap_idx < snap_n && snap_idx < ListD) begin
                  load_pattern(cur_code());
                end else begin
                  ph  = PhIdle;
                  tmr = '0;
                end
              end
              default: begin
                ph  = PhIdle;
                tmr = '0;
              end
            endcase
          end
        end
      end
      ReqPoll: begin
        if (sta == '0) begin
          if (empty_run < RunMax) empty_run++;
          present_run = 0;
          if (empty_run >= deb_polls) add_code(CodeNoDevice);
        end else begin
          if (present_run < RunMax) present_run++;
          empty_run = 0;
          if (present_run >= deb_polls) drop_code(CodeNoDevice);
        end
      end
      default: ;
    endcase
    cc  = cur_code();
    lit = ColNone;
    if (ph == PhOn || (ph == PhPause && KindTab[cc] == KindSteady)) lit = ColourTab[cc];
    r.red    = (lit == ColRed);
    r.yellow = (lit == ColYellow);
    r.green  = (lit == ColGreen);
    r.active = (find_code(code) >= 0);
    r.count  = CountW'(n_codes);
    return r;
  endfunction

  task automatic send_item(input logic [ReqW-1:0] req, input logic [CodeW-1:0] code,
                           input logic [StaW-1:0] sta, input logic typed, input led_res_t want);
    led_res_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= req;
    req_ch.status_code   <= code;
    req_ch.station_count <= sta;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = blink_step(req, code, sta);
    pending_leds = {pending_leds, (typed ? want : predicted)};
    @(negedge clk);
  endtask

  task automatic run_random(input int n_items, input int poll_pct, input int empty_until);
    logic [ReqW-1:0]  req;
    logic [CodeW-1:0] code;
    logic [StaW-1:0]  sta;
    int               pick;
    for (int k = 0; k < n_items; k++) begin
      code = CodeW'($urandom_range(0, 15));
      sta  = StaW'($urandom_range(1, 15));
      if ($urandom_range(0, 99) < poll_pct) begin
        req = ReqPoll;
        if (empty_until >= 0 ? k < empty_until : $urandom_range(0, 1) == 0) sta = '0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          req = ReqTick;
        end else if (pick < 73) begin
          req = ReqAdd;
        end else if (pick < 87) begin
          req = ReqRemove;
          // half the time, take away a code that is really there
          if (n_codes > 0 && $urandom_range(0, 1) == 0) begin
            code = codes[$urandom_range(0, n_codes - 1)];
          end
        end else if (pick < 95) begin
          req = ReqQuery;
        end else begin
          req = ReqW'($urandom_range(ReqSpareLo, ReqSpareHi));
        end
      end
      send_item(req, code, sta, 1'b0, '0);
    end
    req_ch.valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      CfgSlow:  slow_hp   = data;
      CfgFast:  fast_hp   = data;
      CfgPause: pause_len = data;
      CfgUnk:   unk_wait  = data;
      CfgDeb:   deb_polls = data[PollW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_timing(input logic [TimeW-1:0] slow, input logic [TimeW-1:0] fast,
                              input logic [TimeW-1:0] pause, input logic [TimeW-1:0] unk,
                              input logic [PollW-1:0] deb);
    while (pending_leds.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    write_reg(CfgSlow, slow);
    write_reg(CfgFast, fast);
    write_reg(CfgPause, pause);
    write_reg(CfgUnk, unk);
    write_reg(CfgDeb, {8'($urandom_range(0, 255)), deb});
    write_reg(CfgIdxW'($urandom_range(CfgSpareLo, CfgSpareHi)), 16'($urandom_range(0, 65535)));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [CountW-1:0] exp_v,
                                      input logic [CountW-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (res_ch.valid && res_ch.ready) begin
      if (pending_leds.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatch_cnt++;
      end else begin
        due = pending_leds.pop_front();
        check_field("red_led", CountW'(due.red), CountW'(res_ch.red_led));
        check_field("ylw_led", CountW'(due.yellow), CountW'(res_ch.ylw_led));
        check_field("grn_led", CountW'(due.green), CountW'(res_ch.grn_led));
        check_field("code_active", CountW'(due.active), CountW'(res_ch.code_active));
        check_field("active_count", due.count, res_ch.active_count);
      end
    end
  end

  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    req_ch.valid         = 1'b0;
    req_ch.req_type      = '0;
    req_ch.status_code   = '0;
    req_ch.station_count = '0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_data             = '0;

    slow_hp   = RstSlow;
    fast_hp   = RstFast;
    pause_len = RstPause;
    unk_wait  = RstUnk;
    deb_polls = RstDeb;
    foreach (codes[i]) begin
      codes[i] = '0;
      snap[i]  = '0;
    end
    codes[0]    = CodeInit;
    n_codes     = 1;
    snap_n      = 0;
    snap_idx    = 0;
    ph          = PhIdle;
    blinks      = 0;
    tmr         = '0;
    empty_run   = 0;
    present_run = 0;

    dir_tab = '{
      '{ReqQuery,    4'd0,  4'd0,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 3'd1}},
      '{ReqQuery,    4'd15, 4'd0,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 3'd1}},
      '{ReqRemove,   4'd0,  4'd0,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 3'd0}},
      // round start with nothing active
      '{ReqTick,     4'd0,  4'd0,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 3'd0}},
      '{ReqRemove,   4'd0,  4'd0,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 3'd0}},
      '{ReqAdd,      4'd1,  4'd0,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 3'd1}},
      '{ReqAdd,      4'd0,  4'd0,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 3'd1}},
      '{ReqTick,     4'd0,  4'd0,  1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, 3'd1}},
      '{ReqAdd,      4'd3,  4'd0,  1'b0, '0},
      '{ReqAdd,      4'd15, 4'd0,  1'b0, '0},
      '{ReqAdd,      4'd4,  4'd0,  1'b0, '0},
      '{ReqAdd,      4'd5,  4'd0,  1'b0, '0},
      '{ReqAdd,      4'd6,  4'd0,  1'b0, '0},
      // list full
      '{ReqAdd,      4'd7,  4'd0,  1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 3'd6}},
      '{ReqAdd,      4'd1,  4'd0,  1'b0, '0},
      '{ReqRemove,   4'd15, 4'd0,  1'b0, '0},
      '{ReqSpareLo,  4'd3,  4'd15, 1'b0, '0},
      '{ReqSpareHi,  4'd8,  4'd10, 1'b0, '0},
      '{ReqPoll,     4'd9,  4'd0,  1'b0, '0},
      '{ReqPoll,     4'd9,  4'd0,  1'b0, '0},
      '{ReqPoll,     4'd9,  4'd15, 1'b0, '0},
      '{ReqPoll,     4'd9,  4'd6,  1'b0, '0},
      '{ReqSpareMid, 4'd9,  4'd5,  1'b0, '0},
      '{ReqTick,     4'd13, 4'd0,  1'b0, '0}
    };

    repeat (4) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].req, dir_tab[i].code, dir_tab[i].sta, dir_tab[i].typed,
                dir_tab[i].want);
    end
    run_random(150, 12, -1);

    apply_timing(16'd2, 16'd1, 16'd3, 16'd2, 8'd1);
    hold_left = HoldCycles;
    run_random(350, 12, -1);

    // zero timings and zero debounce
    apply_timing('0, '0, '0, '0, '0);
    run_random(250, 12, -1);

    apply_timing(16'd3, 16'd2, 16'd1, 16'd4, 8'd3);
    run_random(250, 15, -1);

    // long empty stretch drives the poll run into saturation
    apply_timing('1, '1, '1, '1, '1);
    run_random(400, 80, 330);

    apply_timing(16'd1, 16'd1, 16'd1, 16'd1, 8'd1);
    idle_on = 1'b0;
    run_random(250, 12, -1);

    while (pending_leds.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== status_led_blink_sequencer_core.f =====
hw/rtl/slbs_pkg.sv
hw/rtl/slbs_req_if.sv
hw/rtl/slbs_res_if.sv
hw/rtl/slbs_ctrl.sv
hw/rtl/slbs_dpath.sv
hw/rtl/status_led_blink_sequencer_core.sv
sim/tb_status_led_blink_sequencer_core.sv
